// ===== sv/tripwire_and_polygon_zone_detect_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the tripwire and polygon zone detector
// Each macro expands to a concurrent assertion clocked by clock and disabled
// during reset, or to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef TRIPWIRE_AND_POLYGON_ZONE_DETECT_DEFINES_SVH
`define TRIPWIRE_AND_POLYGON_ZONE_DETECT_DEFINES_SVH

`ifndef SYNTH
// The consequent must hold in the same cycle as the antecedent.
`define TZD_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("same-cycle check failed");
// The consequent must hold in the cycle after the antecedent.
`define TZD_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define TZD_ASSERT_IMP(lbl, ante, cons)
`define TZD_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== sv/tzd_pkg.sv =====
// ----------------------------------------------------------------------------
// tzd_pkg
// Types, constants and geometry helpers shared by the zone detector modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tzd_pkg;

   localparam int COORD_BITS   = 16;
   localparam int PT_BITS      = COORD_BITS + 2;
   localparam int PROD_BITS    = 2 * PT_BITS;
   localparam int ID_BITS      = 64;
   localparam int TRACK_SLOTS  = 64;
   localparam int SLOT_BITS    = $clog2(TRACK_SLOTS);
   localparam int MAX_VERTICES = 12;
   localparam int VREG_COUNT   = 6;
   localparam int VREG_BITS    = 64;
   localparam int CNT_BITS     = 4;
   localparam int CSR_IDX_BITS = 3;

   localparam logic [CSR_IDX_BITS-1:0] CSR_VERTEX_COUNT   = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_VERTICES_FIRST = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_VERTICES_LAST  = 3'd6;

   typedef enum logic [2:0] {
      V_UNKNOWN      = 3'd0,
      V_ON_LINE      = 3'd1,
      V_CROSS_POS    = 3'd2,
      V_CROSS_NEG    = 3'd3,
      V_NO_INTERSECT = 3'd4,
      V_INSIDE       = 3'd5,
      V_OUTSIDE      = 3'd6
   } verdict_type;

   typedef enum logic [1:0] {
      ORI_ZERO = 2'd0,
      ORI_POS  = 2'd1,
      ORI_NEG  = 2'd2
   } ori_type;

   typedef enum logic [1:0] {
      KIND_UNKNOWN = 2'd0,
      KIND_LINE    = 2'd1,
      KIND_POLY    = 2'd2
   } kind_type;

   typedef struct packed {
      logic signed [PT_BITS-1:0] x;
      logic signed [PT_BITS-1:0] y;
   } pt_type;

   typedef struct packed {
      logic [CNT_BITS-1:0]                   count;
      logic [VREG_COUNT-1:0][VREG_BITS-1:0] vreg;
   } cfg_type;

   typedef struct packed {
      kind_type              kind;
      logic [CNT_BITS-1:0]   edges;
      logic [COORD_BITS-1:0] cur_x;
      logic [COORD_BITS-1:0] cur_y;
      logic                  known_track;
      logic [COORD_BITS-1:0] prev_x;
      logic [COORD_BITS-1:0] prev_y;
   } job_type;

   function automatic pt_type pt_of(input logic [COORD_BITS-1:0] x,
                                    input logic [COORD_BITS-1:0] y);
      pt_type p;
      p.x = $signed({2'b00, x});
      p.y = $signed({2'b00, y});
      return p;
   endfunction

   // Vertex k sits in register k/2; odd vertices occupy the upper half.
   function automatic pt_type vertex_at(input cfg_type cfg,
                                        input logic [CNT_BITS-1:0] k);
      logic [CNT_BITS-2:0]  idx;
      logic [VREG_BITS-1:0] w;
      logic [31:0]          half;
      idx  = k[CNT_BITS-1:1];
      w    = (idx < (CNT_BITS-1)'(VREG_COUNT)) ? cfg.vreg[idx] : '0;
      half = k[0] ? w[63:32] : w[31:0];
      return pt_of(half[COORD_BITS-1:0], half[16 +: COORD_BITS]);
   endfunction

   // True when q lies in the bounding box spanned by p and r.
   function automatic logic in_box(input pt_type p, input pt_type q, input pt_type r);
      logic signed [PT_BITS-1:0] hx;
      logic signed [PT_BITS-1:0] lx;
      logic signed [PT_BITS-1:0] hy;
      logic signed [PT_BITS-1:0] ly;
      hx = (p.x > r.x) ? p.x : r.x;
      lx = (p.x < r.x) ? p.x : r.x;
      hy = (p.y > r.y) ? p.y : r.y;
      ly = (p.y < r.y) ? p.y : r.y;
      return (q.x <= hx) && (q.x >= lx) && (q.y <= hy) && (q.y >= ly);
   endfunction

endpackage

`default_nettype wire

// ===== sv/tzd_front.sv =====
// ----------------------------------------------------------------------------
// tzd_front
// Accepts words, classifies them against the vertex set and looks up and
// updates the per-object track table.
// ----------------------------------------------------------------------------
`default_nettype none

module tzd_front import tzd_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cfg_type               cfg,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [ID_BITS-1:0]    req_object_id,
   input  wire logic [COORD_BITS-1:0] req_pos_x,
   input  wire logic [COORD_BITS-1:0] req_pos_y,
   output logic                       push,
   output job_type                    job,
   input  wire logic                  full
);

   typedef enum logic {F_IDLE, F_LOOK} state_type;

   typedef struct packed {
      logic [ID_BITS-1:0]    tag;
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
   } slot_type;

   state_type             state_ff;
   logic [TRACK_SLOTS-1:0] valid_ff;
   slot_type              tbl_ff [TRACK_SLOTS];
   slot_type              rd_ff;
   logic [ID_BITS-1:0]    id_ff;
   logic [COORD_BITS-1:0] x_ff;
   logic [COORD_BITS-1:0] y_ff;
   logic [SLOT_BITS-1:0]  slot_ff;

   logic                  accept;
   logic                  bad;
   logic                  closing;
   logic [CNT_BITS-1:0]   n;
   logic [CNT_BITS-1:0]   edges;
   pt_type                v_first;
   pt_type                v_last;
   kind_type              kind;
   logic                  tbl_we;

   assign req_stall = (state_ff != F_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      n       = cfg.count;
      v_first = vertex_at(cfg, '0);
      v_last  = vertex_at(cfg, n - 1'b1);
      bad     = (id_ff == '1) || (n < CNT_BITS'(2)) || (n > CNT_BITS'(MAX_VERTICES));
      closing = (n > CNT_BITS'(2)) && (v_first != v_last);
      edges   = n - 1'b1 + CNT_BITS'(closing);
      if (bad || edges == CNT_BITS'(2)) begin
         kind = KIND_UNKNOWN;
      end else if (n == CNT_BITS'(2)) begin
         kind = KIND_LINE;
      end else begin
         kind = KIND_POLY;
      end
   end

   assign push   = (state_ff == F_LOOK) && !full;
   assign tbl_we = push && (kind != KIND_UNKNOWN);

   always_comb begin
      job.kind        = kind;
      job.edges       = edges;
      job.cur_x       = x_ff;
      job.cur_y       = y_ff;
      job.known_track = valid_ff[slot_ff] && (rd_ff.tag == id_ff);
      job.prev_x      = rd_ff.x;
      job.prev_y      = rd_ff.y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         valid_ff <= '0;
      end else begin
         unique case (state_ff)
            F_IDLE: begin
               if (accept) begin
                  state_ff <= F_LOOK;
               end
            end
            F_LOOK: begin
               if (push) begin
                  state_ff <= F_IDLE;
               end
               if (tbl_we) begin
                  valid_ff[slot_ff] <= 1'b1;
               end
            end
            default: state_ff <= F_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         id_ff   <= req_object_id;
         x_ff    <= req_pos_x;
         y_ff    <= req_pos_y;
         slot_ff <= req_object_id[SLOT_BITS-1:0];
      end
   end

   // The table write of one word lands before the next word's read.
   always_ff @(posedge clock) begin
      if (tbl_we) begin
         tbl_ff[slot_ff] <= '{tag: id_ff, x: x_ff, y: y_ff};
      end
      if (accept) begin
         rd_ff <= tbl_ff[req_object_id[SLOT_BITS-1:0]];
      end
   end

endmodule

`default_nettype wire

// ===== sv/tzd_queue.sv =====
// ----------------------------------------------------------------------------
// tzd_queue
// Two-entry queue of classified words between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

`include "tripwire_and_polygon_zone_detect_defines.svh"

module tzd_queue import tzd_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_job,
   output logic         full,
   input  wire logic    pop,
   output job_type      pop_job,
   output logic         empty
);

   localparam int DEPTH = 2;

   job_type    mem_ff [DEPTH];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;

   assign full    = (count_ff == 2'(DEPTH));
   assign empty   = (count_ff == 2'd0);
   assign pop_job = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   `TZD_ASSERT_IMP(a_no_push_full, push, !full)
   `TZD_ASSERT_IMP(a_no_pop_empty, pop, !empty)
   `TZD_ASSERT_NXT(a_push_grows, push && !pop, count_ff == $past(count_ff) + 2'd1)
   `TZD_ASSERT_IMP(a_ptr_match, count_ff == 2'd0 || count_ff == 2'(DEPTH),
                   wr_ptr_ff == rd_ptr_ff)

endmodule

`default_nettype wire

// ===== sv/tzd_back.sv =====
// ----------------------------------------------------------------------------
// tzd_back
// Runs the segment intersection tests on one shared orientation unit and
// holds the verdict in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tzd_back import tzd_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cfg_type cfg,
   input  wire job_type job,
   input  wire logic    empty,
   output logic         pop,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output logic [2:0]   rsp_verdict
);

   typedef enum logic {B_IDLE, B_RUN} state_type;

   localparam logic [2:0] LAST_STEP = 3'd4;

   state_type                   state_ff;
   job_type                     job_ff;
   logic [CNT_BITS-1:0]         edge_ff;
   logic [2:0]                  step_ff;
   ori_type                     o_ff [3];
   logic signed [PROD_BITS-1:0] pa_ff;
   logic signed [PROD_BITS-1:0] pb_ff;
   logic                        parity_ff;
   logic                        rsp_valid_ff;
   verdict_type                 rsp_verdict_ff;

   pt_type                      cur;
   pt_type                      prev;
   pt_type                      start;
   pt_type                      e0;
   pt_type                      e1;
   pt_type                      s1a;
   pt_type                      s1b;
   pt_type                      s2a;
   pt_type                      s2b;
   pt_type                      p;
   pt_type                      q;
   pt_type                      r;
   logic [CNT_BITS-1:0]         nxt;
   logic signed [PT_BITS-1:0]   d1;
   logic signed [PT_BITS-1:0]   d2;
   logic signed [PT_BITS-1:0]   d3;
   logic signed [PT_BITS-1:0]   d4;
   logic signed [PROD_BITS:0]   ov;
   ori_type                     ori_now;
   logic                        meet;
   logic                        on_line;
   logic                        parity_in;
   verdict_type                 line_verdict;

   always_comb begin
      cur     = pt_of(job_ff.cur_x, job_ff.cur_y);
      prev    = pt_of(job_ff.prev_x, job_ff.prev_y);
      start.x = -PT_BITS'(1);
      start.y = cur.y;
      nxt     = edge_ff + 1'b1;
      e0      = vertex_at(cfg, edge_ff);
      e1      = vertex_at(cfg, (nxt < cfg.count) ? nxt : '0);
      if (job_ff.kind == KIND_LINE) begin
         s1a = vertex_at(cfg, CNT_BITS'(0));
         s1b = vertex_at(cfg, CNT_BITS'(1));
         s2a = prev;
         s2b = cur;
      end else begin
         s1a = start;
         s1b = cur;
         s2a = e0;
         s2b = e1;
      end
   end

   // Steps 0 to 3 issue the four orientations of one segment pair.
   always_comb begin
      unique case (step_ff[1:0])
         2'd0: begin p = s1a; q = s1b; r = s2a; end
         2'd1: begin p = s1a; q = s1b; r = s2b; end
         2'd2: begin p = s2a; q = s2b; r = s1a; end
         default: begin p = s2a; q = s2b; r = s1b; end
      endcase
      d1 = q.y - p.y;
      d2 = r.x - q.x;
      d3 = q.x - p.x;
      d4 = r.y - q.y;
   end

   always_comb begin
      ov = (PROD_BITS + 1)'(pa_ff) - (PROD_BITS + 1)'(pb_ff);
      if (ov == '0) begin
         ori_now = ORI_ZERO;
      end else if (ov > 0) begin
         ori_now = ORI_POS;
      end else begin
         ori_now = ORI_NEG;
      end
   end

   always_comb begin
      meet = ((o_ff[0] != o_ff[1]) && (o_ff[2] != ori_now))
          || ((o_ff[0] == ORI_ZERO) && in_box(s1a, s2a, s1b))
          || ((o_ff[1] == ORI_ZERO) && in_box(s1a, s2b, s1b))
          || ((o_ff[2] == ORI_ZERO) && in_box(s2a, s1a, s2b))
          || ((ori_now == ORI_ZERO) && in_box(s2a, s1b, s2b));
      // A negative orientation of a against b means the positive side.
      on_line = (o_ff[1] == ORI_ZERO) && in_box(s1a, cur, s1b);
      priority if (on_line) begin
         line_verdict = V_ON_LINE;
      end else if (!job_ff.known_track) begin
         line_verdict = V_UNKNOWN;
      end else if (!meet) begin
         line_verdict = V_NO_INTERSECT;
      end else if ((o_ff[0] != ORI_NEG) && (o_ff[1] == ORI_NEG)) begin
         line_verdict = V_CROSS_POS;
      end else if ((o_ff[0] != ORI_POS) && (o_ff[1] == ORI_POS)) begin
         line_verdict = V_CROSS_NEG;
      end else begin
         line_verdict = V_UNKNOWN;
      end
      parity_in = parity_ff ^ meet;
   end

   assign pop         = (state_ff == B_IDLE) && !empty && !rsp_valid_ff;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_verdict = rsp_verdict_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            B_IDLE: begin
               if (pop) begin
                  if (job.kind == KIND_UNKNOWN) begin
                     rsp_valid_ff   <= 1'b1;
                     rsp_verdict_ff <= V_UNKNOWN;
                  end else begin
                     state_ff <= B_RUN;
                  end
                  job_ff    <= job;
                  edge_ff   <= '0;
                  step_ff   <= '0;
                  parity_ff <= 1'b0;
               end
            end
            B_RUN: begin
               if (step_ff != 3'd0 && step_ff != LAST_STEP) begin
                  o_ff[step_ff[1:0] - 2'd1] <= ori_now;
               end
               if (step_ff != LAST_STEP) begin
                  step_ff <= step_ff + 3'd1;
               end else if (job_ff.kind == KIND_LINE) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_verdict_ff <= line_verdict;
                  state_ff       <= B_IDLE;
               end else if (edge_ff == job_ff.edges - 1'b1) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_verdict_ff <= parity_in ? V_INSIDE : V_OUTSIDE;
                  state_ff       <= B_IDLE;
               end else begin
                  edge_ff   <= nxt;
                  step_ff   <= '0;
                  parity_ff <= parity_in;
               end
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      pa_ff <= d1 * d2;
      pb_ff <= d3 * d4;
   end

endmodule

`default_nettype wire

// ===== sv/tripwire_and_polygon_zone_detect.sv =====
// ----------------------------------------------------------------------------
// tripwire_and_polygon_zone_detect
// Tripwire crossing and polygon zone test for tracked object positions.
// ----------------------------------------------------------------------------
// Each word carries an object id and a pixel position and yields one verdict
// word. The front part takes a word, reads the object's last position from a
// 64-slot track table and classifies it, and takes no new word until that one
// is pushed into the queue. The back part owns a single orientation unit
// (two 18x18 products per cycle) and works through each segment pair in turn
// after taking the word from the queue; the verdict is then offered, and the
// next word is taken only once it has been accepted. A two-word queue lets the
// front keep accepting while the back works or the result waits.
`default_nettype none

module tripwire_and_polygon_zone_detect import tzd_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_write_enable,
   input  wire logic [CSR_IDX_BITS-1:0] csr_index,
   input  wire logic [VREG_BITS-1:0]    csr_write_data,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic [ID_BITS-1:0]      req_object_id,
   input  wire logic [COORD_BITS-1:0]   req_pos_x,
   input  wire logic [COORD_BITS-1:0]   req_pos_y,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic [2:0]                   rsp_verdict
);

   cfg_type cfg_ff;
   logic    push;
   logic    pop;
   logic    full;
   logic    empty;
   job_type push_job;
   job_type pop_job;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_write_enable) begin
         if (csr_index == CSR_VERTEX_COUNT) begin
            cfg_ff.count <= csr_write_data[CNT_BITS-1:0];
         end else if (csr_index <= CSR_VERTICES_LAST) begin
            cfg_ff.vreg[csr_index - CSR_VERTICES_FIRST] <= csr_write_data;
         end
      end
   end

   tzd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_object_id (req_object_id),
      .req_pos_x     (req_pos_x),
      .req_pos_y     (req_pos_y),
      .push          (push),
      .job           (push_job),
      .full          (full)
   );

   tzd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (full),
      .pop      (pop),
      .pop_job  (pop_job),
      .empty    (empty)
   );

   tzd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .job         (pop_job),
      .empty       (empty),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_verdict (rsp_verdict)
   );

endmodule

`default_nettype wire

// ===== sim/tzd_checker.sv =====
// ----------------------------------------------------------------------------
// Zone detector result checker
// Watches the input and result channels of the zone detector, predicts each
// verdict from its own model of the track table and the vertex set, and
// compares every accepted result word with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tzd_checker import tzd_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_write_enable,
   input  wire logic [CSR_IDX_BITS-1:0] csr_index,
   input  wire logic [VREG_BITS-1:0]    csr_write_data,
   input  wire logic                    req_valid,
   input  wire logic                    req_stall,
   input  wire logic [ID_BITS-1:0]      req_object_id,
   input  wire logic [COORD_BITS-1:0]   req_pos_x,
   input  wire logic [COORD_BITS-1:0]   req_pos_y,
   input  wire logic                    rsp_valid,
   input  wire logic                    rsp_stall,
   input  wire logic [2:0]              rsp_verdict,
   output int                           fail_count,
   output int                           pending_count
);

   typedef struct {
      longint x;
      longint y;
   } gpt_t;

   logic [3:0]  zone_count;
   logic [63:0] zone_reg [VREG_COUNT];
   logic        track_valid [TRACK_SLOTS];
   logic [63:0] track_tag [TRACK_SLOTS];
   logic [15:0] track_x [TRACK_SLOTS];
   logic [15:0] track_y [TRACK_SLOTS];
   verdict_type verdict_queue [$];

   function automatic gpt_t corner(input int k);
      gpt_t p;
      logic [63:0] r;
      int sh;
      r = zone_reg[(k >> 1) % VREG_COUNT];
      sh = (k & 1) ? 32 : 0;
      p.x = longint'((r >> sh) & 64'hFFFF);
      p.y = longint'((r >> (sh + 16)) & 64'hFFFF);
      return p;
   endfunction

   function automatic longint side(input gpt_t a, input gpt_t b, input gpt_t p);
      return (b.x - a.x) * (p.y - a.y) - (b.y - a.y) * (p.x - a.x);
   endfunction

   function automatic int turn(input gpt_t p, input gpt_t q, input gpt_t r);
      longint v;
      v = (q.y - p.y) * (r.x - q.x) - (q.x - p.x) * (r.y - q.y);
      if (v == 0) return 0;
      return (v > 0) ? 1 : 2;
   endfunction

   function automatic bit boxed(input gpt_t p, input gpt_t q, input gpt_t r);
      longint hx, lx, hy, ly;
      hx = (p.x > r.x) ? p.x : r.x;
      lx = (p.x < r.x) ? p.x : r.x;
      hy = (p.y > r.y) ? p.y : r.y;
      ly = (p.y < r.y) ? p.y : r.y;
      return q.x <= hx && q.x >= lx && q.y <= hy && q.y >= ly;
   endfunction

   function automatic bit meets(input gpt_t p1, input gpt_t q1, input gpt_t p2,
                                input gpt_t q2);
      int o1, o2, o3, o4;
      o1 = turn(p1, q1, p2);
      o2 = turn(p1, q1, q2);
      o3 = turn(p2, q2, p1);
      o4 = turn(p2, q2, q1);
      if (o1 != o2 && o3 != o4) return 1;
      if (o1 == 0 && boxed(p1, p2, q1)) return 1;
      if (o2 == 0 && boxed(p1, q2, q1)) return 1;
      if (o3 == 0 && boxed(p2, p1, q2)) return 1;
      if (o4 == 0 && boxed(p2, q1, q2)) return 1;
      return 0;
   endfunction

   // Works out a word's verdict; usable words also update the track table.
   function automatic verdict_type zone_verdict(input logic [63:0] id,
                                                input logic [15:0] px,
                                                input logic [15:0] py);
      gpt_t cur, a, b, prev, start;
      int n, edges, slot, hits;
      bit seen;
      longint cd, pd;
      verdict_type v;
      n = zone_count;
      slot = int'(id % TRACK_SLOTS);
      cur.x = px;
      cur.y = py;
      v = V_UNKNOWN;
      if (id == '1 || n < 2 || n > MAX_VERTICES) return V_UNKNOWN;
      a = corner(0);
      b = corner(n - 1);
      edges = n - 1;
      if (n > 2 && (a.x != b.x || a.y != b.y)) edges++;
      if (edges == 2) return V_UNKNOWN;
      if (edges == 1) begin
         seen = track_valid[slot] && track_tag[slot] == id;
         prev.x = track_x[slot];
         prev.y = track_y[slot];
         b = corner(1);
         cd = side(a, b, cur);
         if (cd == 0 && boxed(a, cur, b)) v = V_ON_LINE;
         else if (seen) begin
            if (meets(a, b, prev, cur)) begin
               pd = side(a, b, prev);
               if (pd <= 0 && cd > 0) v = V_CROSS_POS;
               else if (pd >= 0 && cd < 0) v = V_CROSS_NEG;
               else v = V_UNKNOWN;
            end else v = V_NO_INTERSECT;
         end
      end else begin
         hits = 0;
         start.x = -1;
         start.y = cur.y;
         for (int i = 0; i < edges; i++)
            if (meets(start, cur, corner(i), corner((i + 1 < n) ? i + 1 : 0)))
               hits++;
         v = (hits & 1) ? V_INSIDE : V_OUTSIDE;
      end
      track_valid[slot] = 1;
      track_tag[slot] = id;
      track_x[slot] = px;
      track_y[slot] = py;
      return v;
   endfunction

   always @(posedge clock) begin
      verdict_type want;
      if (reset) begin
         zone_count <= '0;
         for (int i = 0; i < VREG_COUNT; i++) zone_reg[i] = '0;
         for (int i = 0; i < TRACK_SLOTS; i++) track_valid[i] = 0;
         verdict_queue.delete();
         fail_count <= 0;
         pending_count <= 0;
      end else begin
         if (csr_write_enable) begin
            if (csr_index == CSR_VERTEX_COUNT) zone_count <= csr_write_data[3:0];
            else if (csr_index <= CSR_VERTICES_LAST)
               zone_reg[csr_index - CSR_VERTICES_FIRST] = csr_write_data;
         end
         if (req_valid && !req_stall)
            verdict_queue = {verdict_queue,
                             zone_verdict(req_object_id, req_pos_x, req_pos_y)};
         if (rsp_valid && !rsp_stall) begin
            if (verdict_queue.size() == 0) begin
               $error("verdict word with no prediction waiting: %0d", rsp_verdict);
               fail_count <= fail_count + 1;
            end else begin
               want = verdict_queue.pop_front();
               if (rsp_verdict !== want) begin
                  $error("verdict: expected %0d, actual %0d", want, rsp_verdict);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending_count <= verdict_queue.size();
      end
   end

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// Zone detector testbench
// Drives directed and random object positions through several tripwire and
// polygon settings with bursty input and a patterned result stall, and gives
// the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
`default_nettype none

module tb import tzd_pkg::*;;

   logic                    clock = 0;
   logic                    reset = 1;
   logic                    csr_write_enable = 0;
   logic [CSR_IDX_BITS-1:0] csr_index = '0;
   logic [VREG_BITS-1:0]    csr_write_data = '0;
   logic                    req_valid = 0;
   logic                    req_stall;
   logic                    req_stall_seen = 0;
   logic [ID_BITS-1:0]      req_object_id = '0;
   logic [COORD_BITS-1:0]   req_pos_x = '0;
   logic [COORD_BITS-1:0]   req_pos_y = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 0;
   logic [2:0]              rsp_verdict;
   int                      fail_count;
   int                      pending_count;
   int                      cycle_count = 0;
   bit                      hold_off = 0;
   bit                      hold_done = 0;

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   tripwire_and_polygon_zone_detect DUT (.*);
   tzd_checker checker_inst (.*);

   // The stall as it stands just before each rising edge.
   always @(negedge clock) req_stall_seen = req_stall;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 1500000) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Result stall: a shifting pattern, plus one long hold-off to fill the block.
   always @(posedge clock) begin
      int phase;
      phase = (cycle_count / 300) % 4;
      if (hold_off) rsp_stall <= 1;
      else case (phase)
         0: rsp_stall <= 0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 1) == 0);
         default: rsp_stall <= (cycle_count % 7) < 3;
      endcase
   end

   initial begin
      wait (hold_done == 0 && cycle_count == 3000);
      hold_off = 1;
      repeat (400) @(posedge clock);
      hold_off = 0;
      hold_done = 1;
   end

   task automatic csr_write(input logic [CSR_IDX_BITS-1:0] idx, input logic [63:0] data);
      @(posedge clock);
      csr_write_enable <= 1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 0;
   endtask

   function automatic logic [63:0] pair(input logic [15:0] x0, input logic [15:0] y0,
                                        input logic [15:0] x1, input logic [15:0] y1);
      return {y1, x1, y0, x0};
   endfunction

   // Sends one word; the valid stays high across back-to-back words.
   task automatic send_word(input logic [63:0] id, input logic [15:0] x,
                            input logic [15:0] y, input bit last_in_burst);
      req_valid <= 1;
      req_object_id <= id;
      req_pos_x <= x;
      req_pos_y <= y;
      @(posedge clock);
      while (req_stall_seen) @(posedge clock);
      if (last_in_burst) req_valid <= 0;
   endtask

   task automatic drain();
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic random_zone(input int n);
      csr_write(CSR_VERTEX_COUNT, 64'(n));
      for (int r = 0; r < VREG_COUNT; r++) begin
         logic [63:0] d;
         if ($urandom_range(0, 3) == 0) d = {$urandom, $urandom};
         else d = pair(16'($urandom_range(0, 63)), 16'($urandom_range(0, 63)),
                       16'($urandom_range(0, 63)), 16'($urandom_range(0, 63)));
         csr_write(CSR_VERTICES_FIRST + CSR_IDX_BITS'(r), d);
      end
   endtask

   task automatic random_words(input int count);
      int burst;
      logic [63:0] id;
      logic [15:0] x, y;
      burst = 0;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 9))
            0: id = '1;
            1: id = {$urandom, $urandom};
            default: id = $urandom_range(0, 11) + (64'($urandom_range(0, 1)) << 6);
         endcase
         if ($urandom_range(0, 4) == 0) begin
            x = 16'($urandom); y = 16'($urandom);
         end else begin
            x = 16'($urandom_range(0, 70)); y = 16'($urandom_range(0, 70));
         end
         if (burst == 0) burst = $urandom_range(1, 12);
         burst--;
         send_word(id, x, y, burst == 0);
         if (burst == 0) repeat ($urandom_range(0, 6)) @(posedge clock);
      end
      req_valid <= 0;
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 0;
      // Unconfigured block: vertex count zero.
      send_word(5, 0, 0, 1);
      drain();
      // Tripwire along a diagonal; on line, crossings both ways, misses.
      csr_write(CSR_VERTICES_FIRST, pair(10, 10, 50, 50));
      csr_write(CSR_VERTEX_COUNT, 2);
      send_word(3, 30, 30, 0);
      send_word(3, 40, 20, 0);
      send_word(3, 20, 40, 0);
      send_word(3, 40, 20, 0);
      send_word(3, 60, 10, 0);
      send_word(3, 60, 70, 0);
      send_word(67, 40, 40, 0);
      send_word(67, 0, 5, 0);
      send_word('1, 30, 30, 0);
      send_word(64'hFFFF_FFFF_FFFF_FFFE, 16'hFFFF, 16'hFFFF, 0);
      send_word(64'hFFFF_FFFF_FFFF_FFFE, 0, 0, 1);
      drain();
      // Degenerate tripwire with both vertices equal.
      csr_write(CSR_VERTICES_FIRST, pair(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
      send_word(9, 16'hFFFF, 16'hFFFF, 0);
      send_word(9, 1, 2, 1);
      drain();
      // Three vertices, first equal to last: only two segments.
      csr_write(CSR_VERTICES_FIRST, pair(0, 0, 40, 0));
      csr_write(CSR_VERTICES_FIRST + 3'd1, pair(0, 0, 0, 0));
      csr_write(CSR_VERTEX_COUNT, 3);
      send_word(1, 10, 1, 1);
      drain();
      // Triangle, then bad counts above the maximum and below the minimum.
      csr_write(CSR_VERTICES_FIRST + 3'd1, pair(20, 40, 0, 0));
      send_word(1, 20, 10, 0);
      send_word(1, 0, 0, 0);
      send_word(1, 100, 10, 0);
      send_word(1, 20, 40, 1);
      drain();
      csr_write(CSR_VERTEX_COUNT, 15);
      send_word(1, 20, 10, 1);
      drain();
      csr_write(CSR_VERTEX_COUNT, 1);
      send_word(1, 20, 10, 1);
      drain();
      // Random phases across counts, the extremes among them.
      for (int ph = 0; ph < 16; ph++) begin
         int n;
         case (ph % 8)
            0: n = 2;
            1: n = 12;
            2: n = 3;
            3: n = 2;
            4: n = $urandom_range(4, 11);
            5: n = $urandom_range(0, 15);
            default: n = $urandom_range(2, 12);
         endcase
         random_zone(n);
         random_words(78);
         drain();
      end
      if (fail_count == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

endmodule

`default_nettype wire
